### sv/ostt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ostt_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 48;
   localparam int IDX_BITS   = $clog2(NUM_TIMERS);

   localparam int SLOT_BITS  = 4;
   localparam int DELAY_BITS = 41;
   localparam int DUE_BITS   = 48;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [2:0] STATUS_SET_DONE  = 3'd0;
   localparam logic [2:0] STATUS_CANCELLED = 3'd1;
   localparam logic [2:0] STATUS_IDLE_SLOT = 3'd2;
   localparam logic [2:0] STATUS_FIRED     = 3'd3;
   localparam logic [2:0] STATUS_TICK_NONE = 3'd4;

endpackage
`default_nettype wire

### sv/one_shot_timer_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// One-shot timer table. A command is taken when start is high and busy is low.
// Set and cancel give their single result on the rsp_ ports in the cycle
// after the transfer and busy stays low, so a command may be issued every
// cycle. A tick holds busy while the due-time memory is read one slot per
// cycle (registered read) to fire expired slots and find the earliest
// remaining deadline, and then while the fired slots are reported one per
// cycle in ascending slot order; if none fired, a single tick-none result
// is given instead. Results are strobed by rsp_valid for exactly one cycle
// each and cannot be held off; the final result of a command carries
// rsp_last, and busy is low in that cycle.
module one_shot_timer_table_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_op,
   input  wire logic [ostt_pkg::SLOT_BITS-1:0]   req_slot,
   input  wire logic signed [ostt_pkg::DELAY_BITS-1:0] req_delay,
   output logic                                  rsp_valid,
   output logic [2:0]                            rsp_status,
   output logic [ostt_pkg::SLOT_BITS-1:0]        rsp_slot_out,
   output logic                                  rsp_wake,
   output logic [ostt_pkg::DUE_BITS-1:0]         rsp_next_due,
   output logic                                  rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   localparam int NT = ostt_pkg::NUM_TIMERS;
   localparam int IB = ostt_pkg::IDX_BITS;

   state_type state_ff, state_in;
   ostt_pkg::time_type now_ff, now_in;
   ostt_pkg::time_type earliest_ff, earliest_in;
   ostt_pkg::time_type best_ff, best_in;
   logic [NT-1:0] armed_ff, armed_in;
   logic [NT-1:0] fired_ff, fired_in;
   logic [IB:0] scan_cnt_ff, scan_cnt_in;
   logic chk_valid_ff;
   ostt_pkg::idx_type chk_idx_ff;
   ostt_pkg::time_type rd_data_ff;

   ostt_pkg::time_type due_mem [NT];

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [ostt_pkg::SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic rsp_wake_ff, rsp_wake_in;
   ostt_pkg::time_type rsp_due_ff, rsp_due_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic in_range;
   ostt_pkg::idx_type req_idx;
   ostt_pkg::time_type set_due;
   logic set_we;
   logic issue;
   ostt_pkg::idx_type rd_idx;
   logic hit, expired, scan_done;
   ostt_pkg::idx_type pick;
   logic [NT-1:0] pick_mask;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign req_idx  = IB'(req_slot);
   assign in_range = 32'(req_slot) < 32'(NT);
   assign set_due  = now_ff + ostt_pkg::TIME_BITS'($unsigned(req_delay));
   assign set_we   = accept && (req_op == ostt_pkg::OP_SET) && in_range
                     && !req_delay[ostt_pkg::DELAY_BITS-1];

   assign issue  = (state_ff == ST_SCAN) && (scan_cnt_ff < (IB+1)'(NT));
   assign rd_idx = scan_cnt_ff[IB-1:0];

   // Check stage: data of the slot read last cycle
   assign hit       = chk_valid_ff && armed_ff[chk_idx_ff];
   assign expired   = hit && (rd_data_ff < now_ff);
   assign scan_done = chk_valid_ff && (chk_idx_ff == IB'(NT - 1));

   // Lowest pending fired slot
   always_comb begin
      pick = '0;
      for (int i = NT - 1; i >= 0; i--) begin
         if (fired_ff[i]) begin
            pick = IB'(i);
         end
      end
   end
   assign pick_mask = NT'(1) << pick;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      earliest_in   = earliest_ff;
      best_in       = best_ff;
      armed_in      = armed_ff;
      fired_in      = fired_ff;
      scan_cnt_in   = scan_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_wake_in   = 1'b0;
      rsp_due_in    = rsp_due_ff;
      rsp_last_in   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  ostt_pkg::OP_SET: begin
                     if (in_range) begin
                        if (req_delay[ostt_pkg::DELAY_BITS-1]) begin
                           armed_in[req_idx] = 1'b0;
                        end else begin
                           armed_in[req_idx] = 1'b1;
                           if (earliest_ff > set_due) begin
                              earliest_in = set_due;
                              rsp_wake_in = 1'b1;
                           end
                        end
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ostt_pkg::STATUS_SET_DONE;
                     rsp_slot_in   = req_slot;
                     rsp_due_in    = earliest_in;
                  end
                  ostt_pkg::OP_CANCEL: begin
                     rsp_status_in = ostt_pkg::STATUS_IDLE_SLOT;
                     if (in_range && armed_ff[req_idx]) begin
                        armed_in[req_idx] = 1'b0;
                        rsp_status_in     = ostt_pkg::STATUS_CANCELLED;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = req_slot;
                     rsp_due_in   = earliest_ff;
                  end
                  ostt_pkg::OP_TICK: begin
                     now_in      = now_ff + ostt_pkg::TIME_BITS'(1);
                     best_in     = '1;
                     fired_in    = '0;
                     scan_cnt_in = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + (IB+1)'(1);
            end
            if (expired) begin
               armed_in[chk_idx_ff] = 1'b0;
               fired_in[chk_idx_ff] = 1'b1;
            end else if (hit && (rd_data_ff < best_ff)) begin
               best_in = rd_data_ff;
            end
            if (scan_done) begin
               earliest_in = best_in;
               if (fired_in == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ostt_pkg::STATUS_TICK_NONE;
                  rsp_slot_in   = '0;
                  rsp_due_in    = best_in;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            fired_in      = fired_ff & ~pick_mask;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ostt_pkg::STATUS_FIRED;
            rsp_slot_in   = ostt_pkg::SLOT_BITS'(pick);
            rsp_due_in    = earliest_ff;
            rsp_last_in   = (fired_in == '0);
            if (fired_in == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         earliest_ff  <= '1;
         armed_ff     <= '0;
         fired_ff     <= '0;
         scan_cnt_ff  <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         earliest_ff  <= earliest_in;
         armed_ff     <= armed_in;
         fired_ff     <= fired_in;
         scan_cnt_ff  <= scan_cnt_in;
         chk_valid_ff <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff       <= best_in;
      chk_idx_ff    <= rd_idx;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_wake_ff   <= rsp_wake_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Due-time memory: written by set, read during the tick scan
   always_ff @(posedge clock) begin
      if (set_we) begin
         due_mem[req_idx] <= set_due;
      end
      rd_data_ff <= due_mem[rd_idx];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_wake     = rsp_wake_ff;
   assign rsp_next_due = ostt_pkg::DUE_BITS'(rsp_due_ff);
   assign rsp_last     = rsp_last_ff;

endmodule
`default_nettype wire

### sv/ostt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ostt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic [1:0]                       req_op,
   input wire logic                             rsp_valid,
   input wire logic [2:0]                       rsp_status,
   input wire logic [ostt_pkg::SLOT_BITS-1:0]   rsp_slot_out,
   input wire logic                             rsp_wake,
   input wire logic                             rsp_last
);

   // Set and cancel answer in the very next cycle with a single result
   a_quick_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == ostt_pkg::OP_SET || req_op == ostt_pkg::OP_CANCEL))
      |=> (rsp_valid && rsp_last))
      else $error("set/cancel result missing");

   // The final result of a command leaves the block ready
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy after final result");

   // Fired slots come back to back, in ascending slot order
   a_fire_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
      (rsp_valid && rsp_status == ostt_pkg::STATUS_FIRED && rsp_slot_out > $past(rsp_slot_out)))
      else $error("fired slot sequence broken");

   // Only a set can raise wake
   a_wake_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wake) |-> (rsp_status == ostt_pkg::STATUS_SET_DONE))
      else $error("wake on non-set result");

endmodule

bind one_shot_timer_table_unit ostt_checker u_ostt_checker (.*);
`default_nettype wire
